FILE: hw/rtl/fbc_pkg.sv
package fbc_pkg;

    typedef struct packed {
        logic        op;
        logic [63:0] block;
    } t_item;

    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    localparam logic [7:0] FWD_SBOX [0:255] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    localparam logic [7:0] INV_SBOX [0:255] = '{
        8'h52, 8'h09, 8'h6a, 8'hd5, 8'h30, 8'h36, 8'ha5, 8'h38,
        8'hbf, 8'h40, 8'ha3, 8'h9e, 8'h81, 8'hf3, 8'hd7, 8'hfb,
        8'h7c, 8'he3, 8'h39, 8'h82, 8'h9b, 8'h2f, 8'hff, 8'h87,
        8'h34, 8'h8e, 8'h43, 8'h44, 8'hc4, 8'hde, 8'he9, 8'hcb,
        8'h54, 8'h7b, 8'h94, 8'h32, 8'ha6, 8'hc2, 8'h23, 8'h3d,
        8'hee, 8'h4c, 8'h95, 8'h0b, 8'h42, 8'hfa, 8'hc3, 8'h4e,
        8'h08, 8'h2e, 8'ha1, 8'h66, 8'h28, 8'hd9, 8'h24, 8'hb2,
        8'h76, 8'h5b, 8'ha2, 8'h49, 8'h6d, 8'h8b, 8'hd1, 8'h25,
        8'h72, 8'hf8, 8'hf6, 8'h64, 8'h86, 8'h68, 8'h98, 8'h16,
        8'hd4, 8'ha4, 8'h5c, 8'hcc, 8'h5d, 8'h65, 8'hb6, 8'h92,
        8'h6c, 8'h70, 8'h48, 8'h50, 8'hfd, 8'hed, 8'hb9, 8'hda,
        8'h5e, 8'h15, 8'h46, 8'h57, 8'ha7, 8'h8d, 8'h9d, 8'h84,
        8'h90, 8'hd8, 8'hab, 8'h00, 8'h8c, 8'hbc, 8'hd3, 8'h0a,
        8'hf7, 8'he4, 8'h58, 8'h05, 8'hb8, 8'hb3, 8'h45, 8'h06,
        8'hd0, 8'h2c, 8'h1e, 8'h8f, 8'hca, 8'h3f, 8'h0f, 8'h02,
        8'hc1, 8'haf, 8'hbd, 8'h03, 8'h01, 8'h13, 8'h8a, 8'h6b,
        8'h3a, 8'h91, 8'h11, 8'h41, 8'h4f, 8'h67, 8'hdc, 8'hea,
        8'h97, 8'hf2, 8'hcf, 8'hce, 8'hf0, 8'hb4, 8'he6, 8'h73,
        8'h96, 8'hac, 8'h74, 8'h22, 8'he7, 8'had, 8'h35, 8'h85,
        8'he2, 8'hf9, 8'h37, 8'he8, 8'h1c, 8'h75, 8'hdf, 8'h6e,
        8'h47, 8'hf1, 8'h1a, 8'h71, 8'h1d, 8'h29, 8'hc5, 8'h89,
        8'h6f, 8'hb7, 8'h62, 8'h0e, 8'haa, 8'h18, 8'hbe, 8'h1b,
        8'hfc, 8'h56, 8'h3e, 8'h4b, 8'hc6, 8'hd2, 8'h79, 8'h20,
        8'h9a, 8'hdb, 8'hc0, 8'hfe, 8'h78, 8'hcd, 8'h5a, 8'hf4,
        8'h1f, 8'hdd, 8'ha8, 8'h33, 8'h88, 8'h07, 8'hc7, 8'h31,
        8'hb1, 8'h12, 8'h10, 8'h59, 8'h27, 8'h80, 8'hec, 8'h5f,
        8'h60, 8'h51, 8'h7f, 8'ha9, 8'h19, 8'hb5, 8'h4a, 8'h0d,
        8'h2d, 8'he5, 8'h7a, 8'h9f, 8'h93, 8'hc9, 8'h9c, 8'hef,
        8'ha0, 8'he0, 8'h3b, 8'h4d, 8'hae, 8'h2a, 8'hf5, 8'hb0,
        8'hc8, 8'heb, 8'hbb, 8'h3c, 8'h83, 8'h53, 8'h99, 8'h61,
        8'h17, 8'h2b, 8'h04, 8'h7e, 8'hba, 8'h77, 8'hd6, 8'h26,
        8'he1, 8'h69, 8'h14, 8'h63, 8'h55, 8'h21, 8'h0c, 8'h7d
    };

    function automatic logic [31:0] fwd_word(input logic [31:0] x);
        return {FWD_SBOX[x[31:24]], FWD_SBOX[x[23:16]], FWD_SBOX[x[15:8]], FWD_SBOX[x[7:0]]};
    endfunction

    function automatic logic [31:0] inv_word(input logic [31:0] x);
        return {INV_SBOX[x[31:24]], INV_SBOX[x[23:16]], INV_SBOX[x[15:8]], INV_SBOX[x[7:0]]};
    endfunction

    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] dbl;
        dbl = {x, x} << n;
        return dbl[63:32];
    endfunction

endpackage

FILE: hw/rtl/fbc_key.sv
module fbc_key (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic [31:0] i_cipher_key,
    output logic [31:0] o_base_key
);

    logic [31:0] r_base_key;

    // Keep only the substituted key; the rounds never need the raw one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_key <= fbc_pkg::fwd_word(32'h0);
        end else if (i_cfg_valid) begin
            r_base_key <= fbc_pkg::fwd_word(i_cipher_key);
        end
    end

    assign o_base_key = r_base_key;

endmodule

FILE: hw/rtl/fbc_round.sv
module fbc_round #(
    parameter int ROUND_IDX   = 0,
    parameter int ROUND_COUNT = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  fbc_pkg::t_item      i_item,
    input  logic [31:0]         i_base_key,
    output logic                o_valid,
    input  logic                i_ready,
    output fbc_pkg::t_item      o_item
);

    localparam logic [4:0] ENC_ROT = 5'(ROUND_IDX % 32);
    localparam logic [4:0] DEC_ROT = 5'((ROUND_COUNT - 1 - ROUND_IDX) % 32);

    logic           r_valid;
    fbc_pkg::t_item r_item;
    fbc_pkg::t_item n_item;
    logic [31:0]    w_left;
    logic [31:0]    w_right;
    logic [31:0]    w_subkey;
    logic [31:0]    w_f_in;
    logic [31:0]    w_f_out;

    assign w_left  = i_item.block[63:32];
    assign w_right = i_item.block[31:0];

    // Decryption walks the subkeys backward and feeds the left half to F.
    always_comb begin
        if (i_item.op == fbc_pkg::OP_DECRYPT) begin
            w_subkey = fbc_pkg::rotl32(i_base_key, DEC_ROT);
            w_f_in   = w_left;
        end else begin
            w_subkey = fbc_pkg::rotl32(i_base_key, ENC_ROT);
            w_f_in   = w_right;
        end
        w_f_out   = fbc_pkg::inv_word(w_f_in ^ w_subkey);
        n_item.op = i_item.op;
        if (i_item.op == fbc_pkg::OP_DECRYPT) begin
            n_item.block = {w_right ^ w_f_out, w_left};
        end else begin
            n_item.block = {w_right, w_left ^ w_f_out};
        end
    end

    // Take a new transaction when empty or when the current one moves on.
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

FILE: hw/rtl/feistel_block_cipher_64.sv
// 64-bit Feistel block cipher, ROUND_COUNT rounds, one round per register
// stage. A block enters every cycle unless the first stage stalls, and it
// passes in order through the whole chain of round registers, each
// holding one subkey XOR and one byte-substitution layer. Each stage stalls
// only when the stage after it is full and not moving, so bubbles collapse
// under output back-pressure. The key port is always ready; the substituted
// key is registered at the write edge and the first round reads it in the
// next cycle, so write it only while no block is in flight and never at the
// edge that accepts a block. opcode 0 encrypts, 1 decrypts; the left half is
// in bits 63..32 and the halves are not swapped after the last round.
module feistel_block_cipher_64 #(
    parameter int ROUND_COUNT = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cipher_key,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_opcode,
    input  logic [63:0] i_block_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [63:0] o_block_out
);

    logic [31:0]    w_base_key;
    logic [ROUND_COUNT:0] w_valid;
    logic [ROUND_COUNT:0] w_ready;
    fbc_pkg::t_item w_item [0:ROUND_COUNT];

    assign o_cfg_ready = 1'b1;

    fbc_key u_key (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cipher_key (i_cipher_key),
        .o_base_key   (w_base_key)
    );

    assign w_valid[0]       = i_in_valid;
    assign o_in_ready       = w_ready[0];
    assign w_item[0].op     = i_opcode;
    assign w_item[0].block  = i_block_in;

    for (genvar g = 0; g < ROUND_COUNT; g++) begin : g_round
        fbc_round #(
            .ROUND_IDX   (g),
            .ROUND_COUNT (ROUND_COUNT)
        ) u_round (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_valid    (w_valid[g]),
            .o_ready    (w_ready[g]),
            .i_item     (w_item[g]),
            .i_base_key (w_base_key),
            .o_valid    (w_valid[g+1]),
            .i_ready    (w_ready[g+1]),
            .o_item     (w_item[g+1])
        );
    end

    assign w_ready[ROUND_COUNT] = i_out_ready;
    assign o_out_valid          = w_valid[ROUND_COUNT];
    assign o_block_out          = w_item[ROUND_COUNT].block;

    // Input back-pressure only when every stage is full and the sink stalls.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready))
        else $error("input stalled while the pipeline can still move");

    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> w_valid[1])
        else $error("accepted transaction missing from first round stage");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_block_out)))
        else $error("stalled result changed or dropped");

endmodule
